/* hdl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define QRS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define QRS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hdl/qrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int OUT_WIDTH = 40;

    typedef enum logic [1:0] {
        ST_REAL  = 2'd0,
        ST_IMAG  = 2'd1,
        ST_AZERO = 2'd2
    } t_status;

endpackage

/* hdl/quadratic_root_solver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 in signed fixed point.
// ----------------------------------------------------------------------------
// One coefficient set is taken per cycle while o_ready is high, and one result
// comes out per set, in order. The pipeline has three front stages for the
// magnitudes, products and discriminant, one load stage plus one stage per
// root bit of the square root, one numerator stage, one load stage plus one
// stage per quotient bit of the two parallel dividers, and the output register.
// Status 1 (imaginary) and status 2 (a is zero) give zero roots.
module quadratic_root_solver #(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [COEF_WIDTH-1:0]          i_coef_a,
    input  logic [COEF_WIDTH-1:0]          i_coef_b,
    input  logic [COEF_WIDTH-1:0]          i_coef_c,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [qrs_pkg::OUT_WIDTH-1:0]  o_root_plus,
    output logic [qrs_pkg::OUT_WIDTH-1:0]  o_root_minus,
    output logic [1:0]                     o_status
);

`include "assert_macros.svh"

    localparam int W   = COEF_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DW  = 2 * W + 1;
    localparam int RW  = W + 1 + F;
    localparam int XW  = 2 * RW;
    localparam int NB  = W + 2 + F;
    localparam int DB  = W + 1;
    localparam int OW  = qrs_pkg::OUT_WIDTH;
    localparam int EW  = (NB > OW ? NB : OW) + 1;
    localparam int SQW = 2 * W + 4;
    localparam int DVW = 4;
    localparam logic [EW-1:0] LIM = EW'(1) << (OW - 1);

    logic en;

    // stage a: sign and magnitude
    logic         r_a_valid;
    logic         r_a_na, r_a_nb, r_a_nc;
    logic [W-1:0] r_a_ma, r_a_mb, r_a_mc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_na <= i_coef_a[W-1];
            r_a_nb <= i_coef_b[W-1];
            r_a_nc <= i_coef_c[W-1];
            r_a_ma <= i_coef_a[W-1] ? W'(~i_coef_a + W'(1)) : i_coef_a;
            r_a_mb <= i_coef_b[W-1] ? W'(~i_coef_b + W'(1)) : i_coef_b;
            r_a_mc <= i_coef_c[W-1] ? W'(~i_coef_c + W'(1)) : i_coef_c;
        end
    end

    // stage b: products
    logic           r_b_valid;
    logic [2*W-1:0] r_b_p, r_b_q;
    logic           r_b_same;
    logic           r_b_na, r_b_nb;
    logic [W-1:0]   r_b_ma, r_b_mb;
    logic [2*W-1:0] n_p, n_q;

    assign n_p = {{W{1'b0}}, r_a_mb} * {{W{1'b0}}, r_a_mb};
    assign n_q = {{W{1'b0}}, r_a_ma} * {{W{1'b0}}, r_a_mc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_p    <= n_p;
            r_b_q    <= n_q;
            r_b_same <= (r_a_mc != '0) && (r_a_na == r_a_nc);
            r_b_na   <= r_a_na;
            r_b_nb   <= r_a_nb;
            r_b_ma   <= r_a_ma;
            r_b_mb   <= r_a_mb;
        end
    end

    // stage c: discriminant and status
    logic             r_c_valid;
    logic [DW-1:0]    r_c_disc;
    qrs_pkg::t_status r_c_status;
    logic             r_c_na, r_c_nb;
    logic [W-1:0]     r_c_ma, r_c_mb;
    logic [2*W+1:0]   q4;
    logic [2*W+2:0]   dif, sum;
    logic             imag;
    logic [DW-1:0]    n_disc;
    qrs_pkg::t_status n_status;

    assign q4     = {r_b_q, 2'b00};
    assign dif    = {3'b000, r_b_p} - {1'b0, q4};
    assign sum    = {3'b000, r_b_p} + {1'b0, q4};
    assign imag   = r_b_same && dif[2*W+2];
    assign n_disc = r_b_same ? dif[DW-1:0] : sum[DW-1:0];

    always_comb begin
        if (r_b_ma == '0) begin
            n_status = qrs_pkg::ST_AZERO;
        end else if (imag) begin
            n_status = qrs_pkg::ST_IMAG;
        end else begin
            n_status = qrs_pkg::ST_REAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_disc   <= n_disc;
            r_c_status <= n_status;
            r_c_na     <= r_b_na;
            r_c_nb     <= r_b_nb;
            r_c_ma     <= r_b_ma;
            r_c_mb     <= r_b_mb;
        end
    end

    // square root of disc scaled by 2^(2F)
    logic           sq_valid;
    logic [RW-1:0]  sq_root;
    logic [SQW-1:0] sq_side;
    logic [XW-1:0]  sq_x;
    logic [W-1:0]   sq_mb, sq_ma;
    logic           sq_nb, sq_na;
    logic [1:0]     sq_st;

    assign sq_x = XW'(r_c_disc) << (2 * F);

    qrs_sqrt_pipe #(
        .RW (RW),
        .SW (SQW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_valid),
        .i_x     (sq_x),
        .i_side  ({r_c_mb, r_c_nb, r_c_ma, r_c_na, 2'(r_c_status)}),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign {sq_mb, sq_nb, sq_ma, sq_na, sq_st} = sq_side;

    // numerator stage
    logic          r_n_valid;
    logic [NB:0]   r_n_np, r_n_nm;
    logic [W-1:0]  r_n_ma;
    logic          r_n_na;
    logic [1:0]    r_n_st;
    logic [NB-1:0] sb;
    logic [NB:0]   negb, rootx;

    assign sb    = NB'(sq_mb) << F;
    assign negb  = sq_nb ? {1'b0, sb} : ((NB+1)'(0) - {1'b0, sb});
    assign rootx = (NB+1)'(sq_root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else if (en) begin
            r_n_valid <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_np <= negb + rootx;
            r_n_nm <= negb - rootx;
            r_n_ma <= sq_ma;
            r_n_na <= sq_na;
            r_n_st <= sq_st;
        end
    end

    // divide magnitudes by 2|a|
    logic           neg_p, neg_m;
    logic [NB:0]    abs_p, abs_m;
    logic           dv_valid;
    logic [NB-1:0]  dv_qp, dv_qm;
    logic [DVW-1:0] dv_side;
    logic           dv_neg_p, dv_neg_m;
    logic [1:0]     dv_st;

    assign neg_p = r_n_np[NB];
    assign neg_m = r_n_nm[NB];
    assign abs_p = neg_p ? ((NB+1)'(0) - r_n_np) : r_n_np;
    assign abs_m = neg_m ? ((NB+1)'(0) - r_n_nm) : r_n_nm;

    qrs_div_pipe #(
        .NB (NB),
        .DB (DB),
        .SW (DVW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_n_valid),
        .i_num_p (abs_p[NB-1:0]),
        .i_num_m (abs_m[NB-1:0]),
        .i_den   ({r_n_ma, 1'b0}),
        .i_side  ({neg_p ^ r_n_na, neg_m ^ r_n_na, r_n_st}),
        .o_valid (dv_valid),
        .o_quo_p (dv_qp),
        .o_quo_m (dv_qm),
        .o_side  (dv_side)
    );

    assign {dv_neg_p, dv_neg_m, dv_st} = dv_side;

    // sign and saturation
    function automatic logic [OW-1:0] sat_root(input logic [NB-1:0] q, input logic neg);
        logic [EW-1:0] qx;
        logic [EW-1:0] res;
        qx = EW'(q);
        if (neg) begin
            if (qx > LIM) begin
                qx = LIM;
            end
            res = EW'(0) - qx;
        end else begin
            if (qx > LIM - EW'(1)) begin
                qx = LIM - EW'(1);
            end
            res = qx;
        end
        return res[OW-1:0];
    endfunction

    // output register
    logic          r_o_valid;
    logic [OW-1:0] r_o_plus, r_o_minus;
    logic [1:0]    r_o_status;
    logic          out_free;
    logic          real_roots;

    assign out_free   = !r_o_valid || i_ready;
    assign en         = out_free || !dv_valid;
    assign real_roots = (dv_st == qrs_pkg::ST_REAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_o_plus   <= real_roots ? sat_root(dv_qp, dv_neg_p) : '0;
            r_o_minus  <= real_roots ? sat_root(dv_qm, dv_neg_m) : '0;
            r_o_status <= dv_st;
        end
    end

    assign o_ready      = en;
    assign o_valid      = r_o_valid;
    assign o_root_plus  = r_o_plus;
    assign o_root_minus = r_o_minus;
    assign o_status     = r_o_status;

    // checks
    `QRS_ASSERT(a_zero_roots, i_clk, i_rst_n,
        o_valid && (o_status != qrs_pkg::ST_REAL) |-> (o_root_plus == '0) && (o_root_minus == '0),
        "non-real status with nonzero roots")
    `QRS_ASSERT_NEVER(a_stall_cause, i_clk, i_rst_n,
        !o_ready && (!o_valid || i_ready),
        "input stalled while output stage can move")

endmodule

/* hdl/qrs_sqrt_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_sqrt_pipe
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt_pipe #(
    parameter int RW = 33,
    parameter int SW = 36
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_x,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [RW-1:0]   o_root,
    output logic [SW-1:0]   o_side
);

    localparam int XW = 2 * RW;
    localparam int MW = RW + 3;

    logic [MW-1:0] r_rem  [0:RW];
    logic [RW-1:0] r_root [0:RW];
    logic [XW-1:0] r_x    [0:RW];
    logic [SW-1:0] r_side [0:RW];
    logic          r_valid [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_x[0]    <= i_x;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [MW-1:0] rem_in;
        logic [MW-1:0] trial;
        logic          ge;
        logic [MW-1:0] n_rem;
        logic [RW-1:0] n_root;
        logic [XW-1:0] n_x;

        assign rem_in = {r_rem[k][MW-3:0], r_x[k][XW-1 -: 2]};
        assign trial  = {1'b0, r_root[k], 2'b01};
        assign ge     = (rem_in >= trial);
        assign n_rem  = ge ? (rem_in - trial) : rem_in;
        assign n_root = {r_root[k][RW-2:0], ge};
        assign n_x    = r_x[k] << 2;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= r_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_rem;
                r_root[k+1] <= n_root;
                r_x[k+1]    <= n_x;
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_valid[RW];
    assign o_root  = r_root[RW];
    assign o_side  = r_side[RW];

endmodule

/* hdl/qrs_div_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div_pipe
// Two pipelined restoring dividers sharing one divisor, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module qrs_div_pipe #(
    parameter int NB = 34,
    parameter int DB = 17,
    parameter int SW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NB-1:0] i_num_p,
    input  logic [NB-1:0] i_num_m,
    input  logic [DB-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NB-1:0] o_quo_p,
    output logic [NB-1:0] o_quo_m,
    output logic [SW-1:0] o_side
);

    logic [NB-1:0] r_np   [0:NB];
    logic [NB-1:0] r_nm   [0:NB];
    logic [DB-1:0] r_rp   [0:NB];
    logic [DB-1:0] r_rm   [0:NB];
    logic [DB-1:0] r_den  [0:NB];
    logic [SW-1:0] r_side [0:NB];
    logic          r_valid [0:NB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_np[0]   <= i_num_p;
            r_nm[0]   <= i_num_m;
            r_rp[0]   <= '0;
            r_rm[0]   <= '0;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < NB; k++) begin : g_stage
        logic [DB:0]   rin_p;
        logic [DB:0]   rin_m;
        logic [DB:0]   dx;
        logic          ge_p;
        logic          ge_m;
        logic [DB:0]   dif_p;
        logic [DB:0]   dif_m;
        logic [DB-1:0] n_rp;
        logic [DB-1:0] n_rm;
        logic [NB-1:0] n_np;
        logic [NB-1:0] n_nm;

        assign rin_p = {r_rp[k], r_np[k][NB-1]};
        assign rin_m = {r_rm[k], r_nm[k][NB-1]};
        assign dx    = {1'b0, r_den[k]};
        assign ge_p  = (rin_p >= dx);
        assign ge_m  = (rin_m >= dx);
        assign dif_p = rin_p - dx;
        assign dif_m = rin_m - dx;
        assign n_rp  = ge_p ? dif_p[DB-1:0] : rin_p[DB-1:0];
        assign n_rm  = ge_m ? dif_m[DB-1:0] : rin_m[DB-1:0];
        assign n_np  = {r_np[k][NB-2:0], ge_p};
        assign n_nm  = {r_nm[k][NB-2:0], ge_m};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= r_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_np[k+1]   <= n_np;
                r_nm[k+1]   <= n_nm;
                r_rp[k+1]   <= n_rp;
                r_rm[k+1]   <= n_rm;
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_valid[NB];
    assign o_quo_p = r_np[NB];
    assign o_quo_m = r_nm[NB];
    assign o_side  = r_side[NB];

endmodule
